// ===== rtl/binary_trie_prefix_match_defines.svh =====
// assertion macros for the rtl
// each macro expects clk and rst in scope
`ifndef BINARY_TRIE_PREFIX_MATCH_DEFINES_SVH
`define BINARY_TRIE_PREFIX_MATCH_DEFINES_SVH

// same-cycle implication
`define BTPM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BTPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/btpm_pkg.sv =====
`timescale 1ns / 1ps

package btpm_pkg;

  localparam int NODE_POOL = 1024;
  localparam int MAX_BITS  = 32;
  localparam int ADDR_W    = 32;
  localparam int LEN_W     = 6;
  localparam int IDX_W     = $clog2(NODE_POOL);
  localparam int USED_W    = $clog2(NODE_POOL + 1);
  localparam int LEN_LIMIT = (MAX_BITS < ADDR_W) ? MAX_BITS : ADDR_W;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  typedef logic [IDX_W-1:0] node_idx_t;

  typedef struct packed {
    node_idx_t child1;
    node_idx_t child0;
    logic      is_end;
    logic      subnet;
  } node_t;

  typedef struct packed {
    logic      en;
    node_idx_t idx;
  } rd_req_t;

  typedef struct packed {
    logic      en;
    node_idx_t idx;
    node_t     data;
  } wr_req_t;

endpackage

// ===== rtl/btpm_req_if.sv =====
`timescale 1ns / 1ps

interface btpm_req_if import btpm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [ADDR_W-1:0] address_bits;
  logic [LEN_W-1:0]  bit_count;
  logic              is_wildcard;

  modport source (output valid, kind, address_bits, bit_count, is_wildcard, input ready);
  modport sink   (input valid, kind, address_bits, bit_count, is_wildcard, output ready);
endinterface

// ===== rtl/btpm_rsp_if.sv =====
`timescale 1ns / 1ps

interface btpm_rsp_if import btpm_pkg::*; ();
  logic valid;
  logic ready;
  logic matched;
  logic pool_full;

  modport source (output valid, matched, pool_full, input ready);
  modport sink   (input valid, matched, pool_full, output ready);
endinterface

// ===== rtl/btpm_node_store.sv =====
`timescale 1ns / 1ps

module btpm_node_store import btpm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  rd_req_t rd,
  input  wr_req_t wr,
  output node_t   rd_data
);

  // entry 0 of the array stays unused, the root lives in a register
  node_t mem [NODE_POOL];
  node_t root;

  always_ff @(posedge clk) begin
    if (wr.en && (wr.idx != '0)) begin
      mem[wr.idx] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root <= '0;
    end else if (wr.en && (wr.idx == '0)) begin
      root <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= (rd.idx == '0) ? root : mem[rd.idx];
    end
  end

endmodule

// ===== rtl/binary_trie_prefix_match.sv =====
`timescale 1ns / 1ps
// binary trie prefix matcher, one node visited per walk step
// query: from the root, one node per step until a subnet flag, the last bit or a missing child
// insert: existing nodes are walked; a new node is linked into its parent, then cleared in S_ALLOC
// one transaction in flight: the next request is accepted only back in S_IDLE, after S_FINISH
// has registered the result, which waits while a held result blocks the finish step
// rst (synchronous, active high) empties the trie: root cleared, one node in use

module binary_trie_prefix_match import btpm_pkg::*; (
  input logic         clk,
  input logic         rst,
  btpm_req_if.sink    req,
  btpm_rsp_if.source  rsp
);

  `include "binary_trie_prefix_match_defines.svh"

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_EVAL   = 4'b0010,
    S_ALLOC  = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t            state, state_next;
  logic              kind_q, kind_q_next;
  logic              wild_q, wild_q_next;
  logic [ADDR_W-1:0] addr_sh, addr_sh_next;    // current bit sits at the top
  logic [LEN_W-1:0]  remaining, remaining_next; // bits still to walk
  node_idx_t         cur, cur_next;            // node under evaluation
  logic              fresh, fresh_next;        // read data belongs to cur
  logic [USED_W-1:0] nodes_used, nodes_used_next;
  logic              res_matched, res_matched_next;
  logic              res_full, res_full_next;
  logic              out_valid, out_valid_next;
  logic              out_matched, out_matched_next;
  logic              out_full, out_full_next;

  rd_req_t           rd;
  wr_req_t           wr;
  node_t             rd_data;
  node_t             node;
  node_t             node_upd;
  node_idx_t         nxt;
  node_idx_t         new_idx;
  logic              bit_now;
  logic              accept;
  logic [LEN_W-1:0]  len_clamped;
  logic [LEN_W-1:0]  shift_amt;

  btpm_node_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd      (rd),
    .wr      (wr),
    .rd_data (rd_data)
  );

  // handshake
  assign req.ready     = (state == S_IDLE);
  assign accept        = req.valid && req.ready;
  assign rsp.valid     = out_valid;
  assign rsp.matched   = out_matched;
  assign rsp.pool_full = out_full;

  // lengths past the limit saturate; left-align the used bits
  assign len_clamped = (req.bit_count > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT) : req.bit_count;
  assign shift_amt   = LEN_W'(ADDR_W) - len_clamped;

  // a freshly made node is known to be empty, no read needed
  assign node    = fresh ? rd_data : '0;
  assign bit_now = addr_sh[ADDR_W-1];
  assign nxt     = bit_now ? node.child1 : node.child0;
  assign new_idx = nodes_used[IDX_W-1:0];

  always_comb begin
    node_upd = node;
    if (remaining == '0) begin
      // walk finished: mark the last node
      if (wild_q) begin
        node_upd.subnet = 1'b1;
      end else begin
        node_upd.is_end = 1'b1;
      end
    end else if (bit_now) begin
      node_upd.child1 = new_idx;
    end else begin
      node_upd.child0 = new_idx;
    end
  end

  always_comb begin
    state_next       = state;
    kind_q_next      = kind_q;
    wild_q_next      = wild_q;
    addr_sh_next     = addr_sh;
    remaining_next   = remaining;
    cur_next         = cur;
    fresh_next       = fresh;
    nodes_used_next  = nodes_used;
    res_matched_next = res_matched;
    res_full_next    = res_full;
    out_valid_next   = out_valid && !rsp.ready;
    out_matched_next = out_matched;
    out_full_next    = out_full;
    rd               = '0;
    wr               = '0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          kind_q_next      = req.kind;
          wild_q_next      = req.is_wildcard;
          addr_sh_next     = req.address_bits << shift_amt;
          remaining_next   = len_clamped;
          cur_next         = '0;
          fresh_next       = 1'b1;
          res_matched_next = 1'b0;
          res_full_next    = 1'b0;
          rd.en            = 1'b1;
          rd.idx           = '0;
          state_next       = S_EVAL;
        end
      end

      S_EVAL: begin
        if (kind_q == KIND_QUERY) begin
          if (node.subnet) begin
            res_matched_next = 1'b1;
            state_next       = S_FINISH;
          end else if (remaining == '0) begin
            res_matched_next = node.is_end;
            state_next       = S_FINISH;
          end else if (nxt == '0) begin
            // path ends early, no subnet seen
            state_next       = S_FINISH;
          end else begin
            rd.en          = 1'b1;
            rd.idx         = nxt;
            cur_next       = nxt;
            addr_sh_next   = addr_sh << 1;
            remaining_next = remaining - 1'b1;
            fresh_next     = 1'b1;
          end
        end else begin
          if (remaining == '0) begin
            wr.en      = 1'b1;
            wr.idx     = cur;
            wr.data    = node_upd;
            state_next = S_FINISH;
          end else if (nxt != '0) begin
            rd.en          = 1'b1;
            rd.idx         = nxt;
            cur_next       = nxt;
            addr_sh_next   = addr_sh << 1;
            remaining_next = remaining - 1'b1;
            fresh_next     = 1'b1;
          end else if (nodes_used == USED_W'(NODE_POOL)) begin
            res_full_next = 1'b1;
            state_next    = S_FINISH;
          end else begin
            // link the new child into its parent
            wr.en           = 1'b1;
            wr.idx          = cur;
            wr.data         = node_upd;
            cur_next        = new_idx;
            nodes_used_next = nodes_used + 1'b1;
            addr_sh_next    = addr_sh << 1;
            remaining_next  = remaining - 1'b1;
            state_next      = S_ALLOC;
          end
        end
      end

      S_ALLOC: begin
        // clear the new node so later reads never see stale contents
        wr.en      = 1'b1;
        wr.idx     = cur;
        wr.data    = '0;
        fresh_next = 1'b0;
        state_next = S_EVAL;
      end

      S_FINISH: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next   = 1'b1;
          out_matched_next = res_matched;
          out_full_next    = res_full;
          state_next       = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      nodes_used <= USED_W'(1);
      out_valid  <= 1'b0;
      fresh      <= 1'b0;
    end else begin
      state      <= state_next;
      nodes_used <= nodes_used_next;
      out_valid  <= out_valid_next;
      fresh      <= fresh_next;
    end
  end

  // payload and walk registers
  always_ff @(posedge clk) begin
    kind_q      <= kind_q_next;
    wild_q      <= wild_q_next;
    addr_sh     <= addr_sh_next;
    remaining   <= remaining_next;
    cur         <= cur_next;
    res_matched <= res_matched_next;
    res_full    <= res_full_next;
    out_matched <= out_matched_next;
    out_full    <= out_full_next;
  end

  // checks
  `BTPM_ASSERT_NOW(a_used_range, 1'b1, (nodes_used != '0) && (nodes_used <= USED_W'(NODE_POOL)), "node count out of range")
  `BTPM_ASSERT_NOW(a_one_port_op, rd.en, !wr.en, "node store read and write in one cycle")
  `BTPM_ASSERT_NEXT(a_alloc_empty, state == S_ALLOC, (state == S_EVAL) && !fresh, "new node not evaluated as empty")
  `BTPM_ASSERT_NOW(a_full_no_match, out_valid && out_full, !out_matched, "pool full reported with a match")

endmodule

// ===== bench/tb_binary_trie_prefix_match.sv =====
`timescale 1ns / 1ps

module tb_binary_trie_prefix_match import btpm_pkg::*; ();

  // no transaction on either side for this long means the block has hung
  localparam int IDLE_LIMIT   = 2000;
  // wait after the last expected result, to catch any stray one
  localparam int DRAIN_CYCLES = 80;
  localparam int RANDOM_ITEMS = 400;

  typedef struct {
    logic              kind;
    logic [ADDR_W-1:0] address_bits;
    logic [LEN_W-1:0]  bit_count;
    logic              is_wildcard;
  } trie_req_t;

  typedef struct {
    logic matched;
    logic pool_full;
  } trie_rsp_t;

  // a rule as stored, bits right aligned and length already saturated
  typedef struct {
    logic [63:0] bits;
    int          len;
  } rule_t;

  // shadow copy of the trie plus the queue of outcomes still to come
  class trie_scoreboard;
    node_t     nodes [NODE_POOL];
    int        nodes_used;
    trie_rsp_t outcomes [$];
    int        errors;
    int        inserts;
    int        queries;
    int        hits;
    int        full_inserts;

    function new();
      foreach (nodes[n]) nodes[n] = '0;
      nodes_used   = 1;
      errors       = 0;
      inserts      = 0;
      queries      = 0;
      hits         = 0;
      full_inserts = 0;
    endfunction

    // walk the shadow trie for one transaction, growing it on inserts
    function trie_rsp_t walk_trie(trie_req_t r);
      trie_rsp_t res;
      int        len;
      int        cur;
      int        nxt;
      logic      b;
      logic      stop;
      logic      reached;
      res.matched   = 1'b0;
      res.pool_full = 1'b0;
      len = (int'(r.bit_count) > LEN_LIMIT) ? LEN_LIMIT : int'(r.bit_count);
      cur = 0;
      if (r.kind == KIND_INSERT) begin
        stop = 1'b0;
        for (int k = 0; k < len && !stop; k++) begin
          b   = r.address_bits[len-1-k];
          nxt = b ? int'(nodes[cur].child1) : int'(nodes[cur].child0);
          if (nxt == 0) begin
            if (nodes_used >= NODE_POOL) begin
              res.pool_full = 1'b1;
              stop          = 1'b1;
            end else begin
              nxt = nodes_used;
              nodes_used++;
              nodes[nxt] = '0;
              if (b) nodes[cur].child1 = node_idx_t'(nxt);
              else nodes[cur].child0 = node_idx_t'(nxt);
            end
          end
          if (!stop) cur = nxt;
        end
        if (!stop) begin
          if (r.is_wildcard) nodes[cur].subnet = 1'b1;
          else nodes[cur].is_end = 1'b1;
        end
      end else begin
        res.matched = nodes[0].subnet;
        reached     = 1'b1;
        for (int k = 0; k < len && !res.matched && reached; k++) begin
          b   = r.address_bits[len-1-k];
          nxt = b ? int'(nodes[cur].child1) : int'(nodes[cur].child0);
          if (nxt == 0) begin
            reached = 1'b0;
          end else begin
            cur = nxt;
            if (nodes[cur].subnet) res.matched = 1'b1;
          end
        end
        if (!res.matched && reached && nodes[cur].is_end) res.matched = 1'b1;
      end
      return res;
    endfunction

    function void note_request(trie_req_t r);
      trie_rsp_t res;
      res = walk_trie(r);
      outcomes.push_back(res);
      if (r.kind == KIND_INSERT) begin
        inserts++;
        if (res.pool_full) full_inserts++;
      end else begin
        queries++;
        if (res.matched) hits++;
      end
    endfunction

    function void check_response(trie_rsp_t got);
      trie_rsp_t want;
      if (outcomes.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, matched %0b pool_full %0b", $time,
                 got.matched, got.pool_full);
      end else begin
        want = outcomes.pop_front();
        if (got.matched !== want.matched) begin
          errors++;
          $display("%0t: matched expected %0b actual %0b", $time, want.matched,
                   got.matched);
        end
        if (got.pool_full !== want.pool_full) begin
          errors++;
          $display("%0t: pool_full expected %0b actual %0b", $time, want.pool_full,
                   got.pool_full);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  btpm_req_if req ();
  btpm_rsp_if rsp ();

  binary_trie_prefix_match i_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  trie_scoreboard shadow_trie;
  rule_t          known_rules [$];
  int             sent_count;
  int             idle_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog: give up once the handshakes have been silent for too long
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: watchdog, no transaction for %0d cycles", $time, idle_cycles);
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // present one request and hold it until the block takes it
  // a random gap comes first, except in the back-to-back stretches
  task automatic send_request(input logic kind, input logic [ADDR_W-1:0] addr,
                              input logic [LEN_W-1:0] cnt, input logic wild);
    trie_req_t r;
    rule_t     ru;
    int        gap;
    r.kind         = kind;
    r.address_bits = addr;
    r.bit_count    = cnt;
    r.is_wildcard  = wild;
    gap = (((sent_count / 40) % 4) == 3) ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid        <= 1'b1;
    req.kind         <= kind;
    req.address_bits <= addr;
    req.bit_count    <= cnt;
    req.is_wildcard  <= wild;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    shadow_trie.note_request(r);
    sent_count++;
    // remember the rule so later queries can aim at it
    if (kind == KIND_INSERT) begin
      ru.len  = (int'(cnt) > LEN_LIMIT) ? LEN_LIMIT : int'(cnt);
      ru.bits = {32'd0, addr} & ((64'd1 << ru.len) - 64'd1);
      known_rules.push_back(ru);
    end
  endtask

  // one random transaction: mostly short rules, and queries that mostly
  // follow a known rule (exactly, longer, shorter or with one bit flipped)
  task automatic random_item();
    rule_t       ru;
    logic [63:0] wide;
    int          rule_len;
    int          ext;
    int          qlen;
    int          pick;
    logic        wild;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) rule_len = $urandom_range(1, 8);
      else if (pick < 80) rule_len = $urandom_range(9, 20);
      else if (pick < 95) rule_len = $urandom_range(21, 32);
      else if (pick < 97) rule_len = 0;
      else rule_len = $urandom_range(33, 63);
      wild = 1'($urandom_range(0, 1));
      // a wildcard on the root would make every later query match
      if (rule_len == 0) wild = 1'b0;
      send_request(KIND_INSERT, $urandom(), LEN_W'(rule_len), wild);
    end else if (known_rules.size() > 0 && $urandom_range(0, 99) < 65) begin
      ru = known_rules[$urandom_range(0, known_rules.size() - 1)];
      case ($urandom_range(0, 3))
        0: begin
          qlen = ru.len;
          wide = ru.bits;
        end
        1: begin
          ext  = (ru.len < LEN_LIMIT) ? $urandom_range(1, LEN_LIMIT - ru.len) : 0;
          qlen = ru.len + ext;
          wide = (ru.bits << ext) | ({32'd0, $urandom()} & ((64'd1 << ext) - 64'd1));
        end
        2: begin
          qlen = $urandom_range(0, ru.len);
          wide = ru.bits >> (ru.len - qlen);
        end
        default: begin
          qlen = ru.len;
          wide = ru.bits;
          if (ru.len > 0) wide = wide ^ (64'd1 << $urandom_range(0, ru.len - 1));
        end
      endcase
      // junk above the used bits must be ignored
      wide = wide | ({$urandom(), $urandom()} << qlen);
      send_request(KIND_QUERY, wide[ADDR_W-1:0], LEN_W'(qlen), 1'($urandom_range(0, 1)));
    end else begin
      send_request(KIND_QUERY, $urandom(), LEN_W'($urandom_range(0, 63)),
                   1'($urandom_range(0, 1)));
    end
  endtask

  // result side: random stalls, with back-to-back stretches now and then
  initial begin
    int        gap;
    int        taken;
    trie_rsp_t got;
    taken = 0;
    rsp.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = (((taken / 32) % 4) == 1) ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        rsp.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      @(posedge clk);
      while (!rsp.valid) @(posedge clk);
      got.matched   = rsp.matched;
      got.pool_full = rsp.pool_full;
      shadow_trie.check_response(got);
      taken++;
    end
  end

  initial begin
    shadow_trie = new();
    sent_count  = 0;
    rst              <= 1'b1;
    req.valid        <= 1'b0;
    req.kind         <= KIND_INSERT;
    req.address_bits <= '0;
    req.bit_count    <= '0;
    req.is_wildcard  <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty trie, zero and full lengths
    send_request(KIND_QUERY, 32'h0000_0000, 6'd0, 1'b0);
    send_request(KIND_QUERY, 32'hFFFF_FFFF, 6'd32, 1'b1);
    // all-ones exact rule, then hit it, stop one short, and fall off early
    send_request(KIND_INSERT, 32'hFFFF_FFFF, 6'd32, 1'b0);
    send_request(KIND_QUERY, 32'hFFFF_FFFF, 6'd32, 1'b0);
    send_request(KIND_QUERY, 32'h7FFF_FFFF, 6'd31, 1'b0);
    send_request(KIND_QUERY, 32'h7FFF_FFFF, 6'd32, 1'b0);
    // all-zeros exact rule, queried with an over-long length that saturates
    send_request(KIND_INSERT, 32'h0000_0000, 6'd32, 1'b0);
    send_request(KIND_QUERY, 32'h0000_0000, 6'd32, 1'b1);
    send_request(KIND_QUERY, 32'h0000_0000, 6'd63, 1'b0);
    // short subnet rule with junk in the unused upper bits
    send_request(KIND_INSERT, 32'hFFFF_FFF5, 6'd3, 1'b1);
    send_request(KIND_QUERY, 32'hA123_4567, 6'd32, 1'b0);
    send_request(KIND_QUERY, 32'hDEAD_BEE5, 6'd3, 1'b0);
    send_request(KIND_QUERY, 32'h0000_0002, 6'd2, 1'b0);
    // flags set on nodes that already exist
    send_request(KIND_QUERY, 32'h0000_0001, 6'd1, 1'b0);
    send_request(KIND_INSERT, 32'h0000_0001, 6'd1, 1'b0);
    send_request(KIND_QUERY, 32'h0000_0001, 6'd1, 1'b0);
    send_request(KIND_INSERT, 32'h0000_0000, 6'd40, 1'b1);
    send_request(KIND_QUERY, 32'h0000_0000, 6'd20, 1'b0);
    // exact rule on the root only affects zero-length queries
    send_request(KIND_INSERT, 32'h1234_5678, 6'd0, 1'b0);
    send_request(KIND_QUERY, 32'h5555_5555, 6'd0, 1'b0);
    send_request(KIND_QUERY, 32'h5555_5555, 6'd7, 1'b1);

    repeat (RANDOM_ITEMS) random_item();

    // use up whatever is left of the pool, then insert into a full pool
    while (shadow_trie.nodes_used < NODE_POOL) begin
      send_request(KIND_INSERT, $urandom(), 6'd32, 1'($urandom_range(0, 1)));
    end
    repeat (4) send_request(KIND_INSERT, $urandom(), 6'd32, 1'b0);
    repeat (10) random_item();
    // wildcard on the root: needs no node, and from here every query matches
    send_request(KIND_INSERT, $urandom(), 6'd0, 1'b1);
    send_request(KIND_QUERY, $urandom(), 6'd32, 1'b0);
    send_request(KIND_QUERY, $urandom(), 6'd0, 1'b1);

    @(posedge clk);
    req.valid <= 1'b0;
    while (shadow_trie.outcomes.size() != 0) @(posedge clk);
    // catch any stray result still on its way
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d inserts (%0d into a full pool) and %0d queries (%0d matched)",
             shadow_trie.inserts, shadow_trie.full_inserts, shadow_trie.queries,
             shadow_trie.hits);
    $display("trie ended with %0d of %0d nodes in use, %0d mismatches",
             shadow_trie.nodes_used, NODE_POOL, shadow_trie.errors);
    if (shadow_trie.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
